/* rtl/power_mode_state_controller_core_assert.svh */
// assertion macros of the power mode controller rtl
`ifndef POWER_MODE_STATE_CONTROLLER_CORE_ASSERT_SVH
`define POWER_MODE_STATE_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PMSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define PMSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pmsc_pkg.sv */
// types, codes and lookup functions of the power mode controller
package pmsc_pkg;

  typedef enum logic [2:0] {
    MODE_ACTIVE,
    MODE_IDLE,
    MODE_STANDBY,
    MODE_SLEEP,
    MODE_LOW_POWER,
    MODE_CRITICAL,
    MODE_ERROR
  } mode_e;

  typedef enum logic [2:0] {
    ACT_ACTIVITY,
    ACT_INACTIVITY,
    ACT_LOW_POWER,
    ACT_CRITICAL,
    ACT_ERROR,
    ACT_FORCE,
    ACT_REFRESH
  } action_e;

  typedef enum logic [1:0] {
    RCV_NONE,
    RCV_BUSY,
    RCV_OK,
    RCV_FAIL
  } rcv_e;

  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_UNRECOVERABLE,
    FAULT_RECOVERY_FAILED
  } fault_e;

  localparam logic [1:0]  REG_IDLE_TIMEOUT   = 2'd0;
  localparam logic [1:0]  REG_ERROR_LIMIT    = 2'd1;
  localparam logic [1:0]  REG_RECOVERY_LIMIT = 2'd2;

  localparam logic [31:0] IDLE_TIMEOUT_RST   = 32'd30000;
  localparam logic [7:0]  ERROR_LIMIT_RST    = 8'd3;
  localparam logic [7:0]  RECOVERY_LIMIT_RST = 8'd3;

  localparam logic [2:0]  STAT_TRANSITIONS   = 3'd4;
  localparam logic [2:0]  STAT_LOW_POWER     = 3'd5;
  localparam logic [2:0]  STAT_CRITICAL      = 3'd6;

  typedef struct packed {
    logic [1:0] motor;
    logic [1:0] sensor;
    logic [1:0] display;
    logic [1:0] comm;
  } enables_t;

  typedef struct packed {
    mode_e      pwr_mode;
    enables_t   en;
    rcv_e       recovery_status;
    fault_e     fault_code;
    logic [7:0] error_tally;
    logic [7:0] attempts_used;
    logic [31:0] stat_value;
  } result_t;

  function automatic enables_t mode_enables(mode_e mode);
    enables_t en;
    case (mode)
      MODE_ACTIVE:    en = '{motor: 2'd3, sensor: 2'd3, display: 2'd3, comm: 2'd3};
      MODE_IDLE:      en = '{motor: 2'd1, sensor: 2'd1, display: 2'd1, comm: 2'd3};
      MODE_STANDBY:   en = '{motor: 2'd0, sensor: 2'd0, display: 2'd1, comm: 2'd1};
      MODE_SLEEP:     en = '{motor: 2'd0, sensor: 2'd0, display: 2'd0, comm: 2'd1};
      MODE_LOW_POWER: en = '{motor: 2'd0, sensor: 2'd0, display: 2'd1, comm: 2'd1};
      default:        en = '{motor: 2'd0, sensor: 2'd0, display: 2'd0, comm: 2'd0};
    endcase
    return en;
  endfunction

endpackage

/* rtl/pmsc_if.sv */
// event and result channel interfaces of the power mode controller
interface pmsc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] now;
  logic [2:0]  target_state;
  logic        recovery_ok;
  logic [2:0]  stat_select;

  modport source (output valid, action, now, target_state, recovery_ok, stat_select,
                  input ready);
  modport sink (input valid, action, now, target_state, recovery_ok, stat_select,
                output ready);
endinterface

interface pmsc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  pwr_mode;
  logic [1:0]  motor_ctrl;
  logic [1:0]  sensor_ctrl;
  logic [1:0]  display_ctrl;
  logic [1:0]  comm_ctrl;
  logic [1:0]  recovery_status;
  logic [1:0]  fault_code;
  logic [7:0]  error_tally;
  logic [7:0]  attempts_used;
  logic [31:0] stat_value;

  modport source (output valid, pwr_mode, motor_ctrl, sensor_ctrl, display_ctrl,
                  comm_ctrl, recovery_status, fault_code, error_tally, attempts_used,
                  stat_value, input ready);
  modport sink (input valid, pwr_mode, motor_ctrl, sensor_ctrl, display_ctrl,
                comm_ctrl, recovery_status, fault_code, error_tally, attempts_used,
                stat_value, output ready);
endinterface

/* rtl/power_mode_state_controller_core.sv */
// Power mode controller: takes one timestamped event beat per clock cycle while stage b is
// not held and returns one result beat for each via stage b and the output register. Mode,
// stamps, event counters and error/recovery counters sit in flops and are updated in the
// cycle an event is accepted. The four per-mode dwell accumulators live in a four-entry
// memory with two registered read ports: the entry of the mode being left and the entry
// chosen by stat_select are read at acceptance, the sum is formed in stage b and written
// back as stage b moves on; a bypass register covers a read meeting that write. Per-entry
// valid bits make the accumulators read as zero after reset, so no clearing pass is needed.
// The configuration port is a plain write port and should be written only while idle.
module power_mode_state_controller_core
  import pmsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pmsc_in_if.sink     in_i,
  pmsc_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  // configuration registers
  logic [31:0] idle_timeout_q;
  logic [7:0]  error_limit_q;
  logic [7:0]  recovery_limit_q;

  // scalar state
  mode_e       mode_q, mode_d;
  logic [31:0] last_act_q, last_act_d;
  logic [31:0] entry_q, entry_d;
  logic [31:0] trans_q, trans_d;
  logic [31:0] lp_q, lp_d;
  logic [31:0] crit_q, crit_d;
  logic [7:0]  err_q, err_d;
  logic [7:0]  att_q, att_d;
  rcv_e        phase_q, phase_d;

  // stage b and output register
  logic        b_vld_q;
  result_t     b_res_q, res_a;
  logic        b_sel_dwell_q;
  logic [1:0]  b_sel_q;
  logic        b_upd_q;
  logic [1:0]  b_upd_addr_q;
  logic [31:0] b_spent_q;
  logic        out_vld_q;
  result_t     out_q, res_b;

  // dwell memory
  logic [31:0] dwell_mem [4];
  logic [3:0]  dwell_vld_q;
  logic [31:0] rd_upd_q, rd_sel_q;
  logic        rd_upd_vld_q, rd_sel_vld_q;
  logic        fwd_vld_q;
  logic [1:0]  fwd_addr_q;
  logic [31:0] fwd_data_q;

  logic        acc, b_go, mem_we;
  logic        go_a, change_a, close_a, upd_a;
  mode_e       tgt_a;
  fault_e      fault_a;
  logic [7:0]  err_inc, att_inc;
  logic [31:0] idle_elapsed;
  logic [31:0] upd_old, upd_new, sel_old;

  assign b_go        = b_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !b_vld_q || b_go;
  assign acc         = in_i.valid && in_i.ready;
  assign mem_we      = b_go && b_upd_q;

  assign err_inc      = err_q + 8'd1;
  assign att_inc      = att_q + 8'd1;
  assign idle_elapsed = in_i.now - last_act_q;

  // event decode and scalar next state
  always_comb begin
    go_a       = 1'b0;
    tgt_a      = mode_q;
    close_a    = 1'b0;
    fault_a    = FAULT_NONE;
    last_act_d = last_act_q;
    lp_d       = lp_q;
    crit_d     = crit_q;
    err_d      = err_q;
    att_d      = att_q;
    phase_d    = phase_q;
    case (action_e'(in_i.action))
      ACT_ACTIVITY: begin
        last_act_d = in_i.now;
        go_a       = 1'b1;
        tgt_a      = MODE_ACTIVE;
      end
      ACT_INACTIVITY: begin
        go_a  = (idle_elapsed >= idle_timeout_q) && (mode_q == MODE_ACTIVE);
        tgt_a = MODE_IDLE;
      end
      ACT_LOW_POWER: begin
        lp_d  = lp_q + 32'd1;
        go_a  = 1'b1;
        tgt_a = MODE_LOW_POWER;
      end
      ACT_CRITICAL: begin
        crit_d = crit_q + 32'd1;
        go_a   = 1'b1;
        tgt_a  = MODE_CRITICAL;
      end
      ACT_ERROR: begin
        err_d = err_inc;
        if (err_inc >= error_limit_q) begin
          if (att_q >= recovery_limit_q) begin
            // attempts exhausted: no further try
            fault_a = FAULT_UNRECOVERABLE;
            go_a    = 1'b1;
            tgt_a   = MODE_ERROR;
          end else begin
            att_d = att_inc;
            if (in_i.recovery_ok) begin
              phase_d = RCV_OK;
              err_d   = 8'd0;
              go_a    = 1'b1;
              tgt_a   = MODE_ACTIVE;
            end else begin
              phase_d = RCV_FAIL;
              fault_a = FAULT_RECOVERY_FAILED;
              go_a    = (att_inc >= recovery_limit_q);
              tgt_a   = MODE_ERROR;
            end
          end
        end
      end
      ACT_FORCE: begin
        if (in_i.target_state <= 3'(MODE_ERROR)) begin
          go_a  = 1'b1;
          tgt_a = mode_e'(in_i.target_state);
        end
      end
      ACT_REFRESH: begin
        close_a = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign change_a = go_a && (tgt_a != mode_q);
  assign upd_a    = (change_a || close_a) && !mode_q[2];

  always_comb begin
    mode_d  = change_a ? tgt_a : mode_q;
    trans_d = change_a ? trans_q + 32'd1 : trans_q;
    entry_d = (change_a || close_a) ? in_i.now : entry_q;
  end

  // result fields known at acceptance; dwell statistics are filled in stage b
  always_comb begin
    res_a.pwr_mode        = mode_d;
    res_a.en              = mode_enables(mode_d);
    res_a.recovery_status = phase_d;
    res_a.fault_code      = fault_a;
    res_a.error_tally     = err_d;
    res_a.attempts_used   = att_d;
    case (in_i.stat_select)
      STAT_TRANSITIONS: res_a.stat_value = trans_d;
      STAT_LOW_POWER:   res_a.stat_value = lp_d;
      STAT_CRITICAL:    res_a.stat_value = crit_d;
      default:          res_a.stat_value = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q   <= IDLE_TIMEOUT_RST;
      error_limit_q    <= ERROR_LIMIT_RST;
      recovery_limit_q <= RECOVERY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IDLE_TIMEOUT:   idle_timeout_q   <= cfg_wdata_i;
        REG_ERROR_LIMIT:    error_limit_q    <= cfg_wdata_i[7:0];
        REG_RECOVERY_LIMIT: recovery_limit_q <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_ACTIVE;
      last_act_q <= '0;
      entry_q    <= '0;
      trans_q    <= '0;
      lp_q       <= '0;
      crit_q     <= '0;
      err_q      <= '0;
      att_q      <= '0;
      phase_q    <= RCV_NONE;
    end else if (acc) begin
      mode_q     <= mode_d;
      last_act_q <= last_act_d;
      entry_q    <= entry_d;
      trans_q    <= trans_d;
      lp_q       <= lp_d;
      crit_q     <= crit_d;
      err_q      <= err_d;
      att_q      <= att_d;
      phase_q    <= phase_d;
    end
  end

  // stage b control and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (acc) begin
      b_vld_q <= 1'b1;
    end else if (b_go) begin
      b_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      b_res_q       <= res_a;
      b_sel_dwell_q <= !in_i.stat_select[2];
      b_sel_q       <= in_i.stat_select[1:0];
      b_upd_q       <= upd_a;
      b_upd_addr_q  <= mode_q[1:0];
      b_spent_q     <= in_i.now - entry_q;
    end
  end

  // dwell memory: two registered read ports, one write port
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_upd_q <= dwell_mem[mode_q[1:0]];
      rd_sel_q <= dwell_mem[in_i.stat_select[1:0]];
    end
    if (mem_we) begin
      dwell_mem[b_upd_addr_q] <= upd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_vld_q  <= '0;
      rd_upd_vld_q <= 1'b0;
      rd_sel_vld_q <= 1'b0;
      fwd_vld_q    <= 1'b0;
      fwd_addr_q   <= '0;
      fwd_data_q   <= '0;
    end else begin
      if (acc) begin
        rd_upd_vld_q <= dwell_vld_q[mode_q[1:0]];
        rd_sel_vld_q <= dwell_vld_q[in_i.stat_select[1:0]];
      end
      if (mem_we) begin
        dwell_vld_q[b_upd_addr_q] <= 1'b1;
        // bypass copy of the latest write, always equal to the memory contents
        fwd_vld_q  <= 1'b1;
        fwd_addr_q <= b_upd_addr_q;
        fwd_data_q <= upd_new;
      end
    end
  end

  always_comb begin
    if (fwd_vld_q && (fwd_addr_q == b_upd_addr_q)) begin
      upd_old = fwd_data_q;
    end else begin
      upd_old = rd_upd_vld_q ? rd_upd_q : 32'd0;
    end
    if (fwd_vld_q && (fwd_addr_q == b_sel_q)) begin
      sel_old = fwd_data_q;
    end else begin
      sel_old = rd_sel_vld_q ? rd_sel_q : 32'd0;
    end
    upd_new = upd_old + b_spent_q;
  end

  always_comb begin
    res_b = b_res_q;
    if (b_sel_dwell_q) begin
      res_b.stat_value = (b_upd_q && (b_upd_addr_q == b_sel_q)) ? upd_new : sel_old;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (b_go) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go) begin
      out_q <= res_b;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.pwr_mode        = out_q.pwr_mode;
  assign out_o.motor_ctrl      = out_q.en.motor;
  assign out_o.sensor_ctrl     = out_q.en.sensor;
  assign out_o.display_ctrl    = out_q.en.display;
  assign out_o.comm_ctrl       = out_q.en.comm;
  assign out_o.recovery_status = out_q.recovery_status;
  assign out_o.fault_code      = out_q.fault_code;
  assign out_o.error_tally     = out_q.error_tally;
  assign out_o.attempts_used   = out_q.attempts_used;
  assign out_o.stat_value      = out_q.stat_value;

`include "power_mode_state_controller_core_assert.svh"

  `PMSC_ASSERT_IMP(a_no_accept_over_stall, clk_i, rst_ni, acc, !b_vld_q || b_go, "beat over stall")
  `PMSC_ASSERT_NXT(a_stage_b_holds, clk_i, rst_ni, b_vld_q && !b_go, b_vld_q && $stable(b_res_q), "stage lost")
  `PMSC_ASSERT_NXT(a_unrec_to_error, clk_i, rst_ni, acc && (fault_a == FAULT_UNRECOVERABLE), mode_q == MODE_ERROR, "no error mode")

endmodule

/* verif/tb.sv */
// self-checking testbench of the power mode controller core
module tb;
  import pmsc_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam logic [2:0] NO_MODE    = 3'd7;
  localparam logic [2:0] STAT_NONE  = 3'd7;

  typedef struct {
    logic [2:0]  action;
    logic [31:0] now;
    logic [2:0]  target;
    logic        ok;
    logic [2:0]  sel;
  } pm_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_wdata;

  pmsc_in_if  ev_if ();
  pmsc_out_if res_if ();

  power_mode_state_controller_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (ev_if),
    .out_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // mirror of the controller state
  logic [31:0] idle_to      = IDLE_TIMEOUT_RST;
  logic [7:0]  error_lim    = ERROR_LIMIT_RST;
  logic [7:0]  recovery_lim = RECOVERY_LIMIT_RST;
  mode_e       cur_mode     = MODE_ACTIVE;
  logic [31:0] last_act     = '0;
  logic [31:0] entry_stamp  = '0;
  logic [31:0] dwell_acc [4] = '{default: '0};
  logic [31:0] trans_total  = '0;
  logic [31:0] lp_total     = '0;
  logic [31:0] crit_total   = '0;
  logic [7:0]  error_cnt    = '0;
  logic [7:0]  attempt_cnt  = '0;
  rcv_e        rcv_phase    = RCV_NONE;

  pm_beat_t     event_q [$];
  result_t      report_q [$];
  pm_beat_t     drive_ev;
  logic [31:0]  stamp_now = '0;

  logic offering     = 1'b0;
  logic event_taken  = 1'b0;
  logic result_taken = 1'b0;
  int   gap_left     = 0;
  int   stall_left   = 0;
  int   hold_left    = 0;
  int   in_gap_max   = 0;
  int   out_stall_max = 0;
  int   mismatch_count = 0;
  int   result_index = 0;

  function automatic void close_dwell(logic [31:0] stamp);
    logic [31:0] spent;
    spent = stamp - entry_stamp;
    if (cur_mode <= MODE_SLEEP) dwell_acc[cur_mode[1:0]] += spent;
    entry_stamp = stamp;
  endfunction

  function automatic void move_to(mode_e target, logic [31:0] stamp);
    if (target != cur_mode) begin
      close_dwell(stamp);
      cur_mode = target;
      trans_total++;
    end
  endfunction

  function automatic fault_e attempt_recovery(logic ok, logic [31:0] stamp);
    if (attempt_cnt >= recovery_lim) begin
      move_to(MODE_ERROR, stamp);
      return FAULT_UNRECOVERABLE;
    end
    attempt_cnt++;
    if (ok) begin
      rcv_phase = RCV_OK;
      error_cnt = '0;
      move_to(MODE_ACTIVE, stamp);
      return FAULT_NONE;
    end
    rcv_phase = RCV_FAIL;
    if (attempt_cnt >= recovery_lim) move_to(MODE_ERROR, stamp);
    return FAULT_RECOVERY_FAILED;
  endfunction

  function automatic result_t step_power_model(logic [2:0] act, logic [31:0] stamp,
                                               logic [2:0] tgt, logic ok, logic [2:0] sel);
    result_t     r;
    fault_e      fault;
    logic [31:0] quiet;
    fault = FAULT_NONE;
    case (act)
      ACT_ACTIVITY: begin
        last_act = stamp;
        move_to(MODE_ACTIVE, stamp);
      end
      ACT_INACTIVITY: begin
        quiet = stamp - last_act;
        if (quiet >= idle_to && cur_mode == MODE_ACTIVE) move_to(MODE_IDLE, stamp);
      end
      ACT_LOW_POWER: begin
        lp_total++;
        move_to(MODE_LOW_POWER, stamp);
      end
      ACT_CRITICAL: begin
        crit_total++;
        move_to(MODE_CRITICAL, stamp);
      end
      ACT_ERROR: begin
        error_cnt++;
        if (error_cnt >= error_lim) fault = attempt_recovery(ok, stamp);
      end
      ACT_FORCE: begin
        if (tgt <= MODE_ERROR) move_to(mode_e'(tgt), stamp);
      end
      ACT_REFRESH: close_dwell(stamp);
      default: ;
    endcase

    r.pwr_mode = cur_mode;
    case (cur_mode)
      MODE_ACTIVE:    r.en = '{motor: 2'd3, sensor: 2'd3, display: 2'd3, comm: 2'd3};
      MODE_IDLE:      r.en = '{motor: 2'd1, sensor: 2'd1, display: 2'd1, comm: 2'd3};
      MODE_STANDBY:   r.en = '{motor: 2'd0, sensor: 2'd0, display: 2'd1, comm: 2'd1};
      MODE_SLEEP:     r.en = '{motor: 2'd0, sensor: 2'd0, display: 2'd0, comm: 2'd1};
      MODE_LOW_POWER: r.en = '{motor: 2'd0, sensor: 2'd0, display: 2'd1, comm: 2'd1};
      default:        r.en = '{motor: 2'd0, sensor: 2'd0, display: 2'd0, comm: 2'd0};
    endcase
    r.recovery_status = rcv_phase;
    r.fault_code      = fault;
    r.error_tally     = error_cnt;
    r.attempts_used   = attempt_cnt;
    if (sel < STAT_TRANSITIONS)       r.stat_value = dwell_acc[sel[1:0]];
    else if (sel == STAT_TRANSITIONS) r.stat_value = trans_total;
    else if (sel == STAT_LOW_POWER)   r.stat_value = lp_total;
    else if (sel == STAT_CRITICAL)    r.stat_value = crit_total;
    else                              r.stat_value = '0;
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("result %0d %s: expected %0h, got %0h", result_index, fname, want, got);
    end
  endtask

  // handshakes are seen at the rising edge only
  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    event_taken = 1'b0;
    result_taken = 1'b0;
    if (rst_ni) begin
      if (ev_if.valid && ev_if.ready) begin
        event_taken = 1'b1;
        report_q.push_back(step_power_model(ev_if.action, ev_if.now, ev_if.target_state,
                                            ev_if.recovery_ok, ev_if.stat_select));
      end
      if (res_if.valid && res_if.ready) begin
        result_taken = 1'b1;
        seen.pwr_mode        = mode_e'(res_if.pwr_mode);
        seen.en.motor        = res_if.motor_ctrl;
        seen.en.sensor       = res_if.sensor_ctrl;
        seen.en.display      = res_if.display_ctrl;
        seen.en.comm         = res_if.comm_ctrl;
        seen.recovery_status = rcv_e'(res_if.recovery_status);
        seen.fault_code      = fault_e'(res_if.fault_code);
        seen.error_tally     = res_if.error_tally;
        seen.attempts_used   = res_if.attempts_used;
        seen.stat_value      = res_if.stat_value;
        if (report_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d arrived with nothing outstanding", result_index);
        end else begin
          want = report_q.pop_front();
          check_field("pwr_mode", 32'(seen.pwr_mode), 32'(want.pwr_mode));
          check_field("motor_ctrl", 32'(seen.en.motor), 32'(want.en.motor));
          check_field("sensor_ctrl", 32'(seen.en.sensor), 32'(want.en.sensor));
          check_field("display_ctrl", 32'(seen.en.display), 32'(want.en.display));
          check_field("comm_ctrl", 32'(seen.en.comm), 32'(want.en.comm));
          check_field("recovery_status", 32'(seen.recovery_status),
                      32'(want.recovery_status));
          check_field("fault_code", 32'(seen.fault_code), 32'(want.fault_code));
          check_field("error_tally", 32'(seen.error_tally), 32'(want.error_tally));
          check_field("attempts_used", 32'(seen.attempts_used), 32'(want.attempts_used));
          check_field("stat_value", seen.stat_value, want.stat_value);
        end
        result_index++;
      end
    end
  end

  // event driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (event_taken) offering = 1'b0;
      if (!offering) begin
        if (gap_left != 0) begin
          gap_left--;
          ev_if.valid <= 1'b0;
        end else if (event_q.size() != 0) begin
          drive_ev = event_q.pop_front();
          ev_if.valid        <= 1'b1;
          ev_if.action       <= drive_ev.action;
          ev_if.now          <= drive_ev.now;
          ev_if.target_state <= drive_ev.target;
          ev_if.recovery_ok  <= drive_ev.ok;
          ev_if.stat_select  <= drive_ev.sel;
          offering = 1'b1;
          gap_left = $urandom_range(0, in_gap_max);
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) stall_left = $urandom_range(0, out_stall_max);
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_event(logic [2:0] act, logic [31:0] stamp, logic [2:0] tgt, logic ok,
                           logic [2:0] sel);
    pm_beat_t ev;
    ev.action = act;
    ev.now    = stamp;
    ev.target = tgt;
    ev.ok     = ok;
    ev.sel    = sel;
    event_q.push_back(ev);
  endtask

  task automatic add_random_events(int count);
    int         pick;
    logic [2:0] act;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20)      act = ACT_ACTIVITY;
      else if (pick < 40) act = ACT_INACTIVITY;
      else if (pick < 50) act = ACT_LOW_POWER;
      else if (pick < 58) act = ACT_CRITICAL;
      else if (pick < 78) act = ACT_ERROR;
      else if (pick < 88) act = ACT_FORCE;
      else if (pick < 97) act = ACT_REFRESH;
      else                act = ACT_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 50)      stamp_now += $urandom_range(0, 300);
      else if (pick < 80) stamp_now += $urandom_range(0, 70000);
      else if (pick < 95) stamp_now += $urandom;
      else                stamp_now = $urandom;
      add_event(act, stamp_now, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                3'($urandom_range(0, 7)));
    end
  endtask

  // wait for the block to drain
  task automatic settle();
    while (event_q.size() != 0 || offering || report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [31:0] timeout, logic [7:0] err_limit,
                              logic [7:0] rcv_limit);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= REG_IDLE_TIMEOUT;
    cfg_wdata <= timeout;
    @(negedge clk_i);
    cfg_idx <= REG_ERROR_LIMIT;
    cfg_wdata <= {24'd0, err_limit};
    @(negedge clk_i);
    cfg_idx <= REG_RECOVERY_LIMIT;
    cfg_wdata <= {24'd0, rcv_limit};
    @(negedge clk_i);
    cfg_we <= 1'b0;
    idle_to = timeout;
    error_lim = err_limit;
    recovery_lim = rcv_limit;
    @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] timeout;
    logic [7:0]  err_limit;
    int          rcv_limit;
    ev_if.valid = 1'b0;
    ev_if.action = ACT_ACTIVITY;
    ev_if.now = '0;
    ev_if.target_state = MODE_ACTIVE;
    ev_if.recovery_ok = 1'b0;
    ev_if.stat_select = '0;
    res_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_IDLE_TIMEOUT;
    cfg_wdata = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed walk through the modes with the reset settings
    in_gap_max = 5;
    out_stall_max = 5;
    add_event(ACT_REFRESH, 32'd0, MODE_ACTIVE, 1'b0, 3'd0);
    add_event(ACT_ACTIVITY, 32'd100, MODE_ACTIVE, 1'b1, STAT_TRANSITIONS);
    add_event(ACT_INACTIVITY, 32'd200, MODE_ACTIVE, 1'b0, 3'd0);
    add_event(ACT_INACTIVITY, 32'd30100, MODE_ACTIVE, 1'b0, STAT_TRANSITIONS);
    add_event(ACT_INACTIVITY, 32'd90000, MODE_ACTIVE, 1'b0, 3'd1);
    add_event(ACT_FORCE, 32'd90010, MODE_STANDBY, 1'b0, 3'd1);
    add_event(ACT_FORCE, 32'd90500, MODE_SLEEP, 1'b0, 3'd2);
    add_event(ACT_FORCE, 32'd91000, NO_MODE, 1'b1, 3'd3);
    add_event(ACT_FORCE, 32'd91200, MODE_SLEEP, 1'b0, STAT_TRANSITIONS);
    add_event(ACT_LOW_POWER, 32'd92000, MODE_ACTIVE, 1'b0, STAT_LOW_POWER);
    add_event(ACT_CRITICAL, 32'd93000, MODE_ACTIVE, 1'b0, STAT_CRITICAL);
    add_event(ACT_REFRESH, 32'd94000, MODE_ACTIVE, 1'b0, 3'd3);
    add_event(ACT_ACTIVITY, 32'd95000, MODE_ACTIVE, 1'b0, STAT_NONE);
    add_event(ACT_UNUSED, 32'd95100, MODE_ERROR, 1'b1, 3'd0);
    add_event(ACT_ERROR, 32'd95200, MODE_ACTIVE, 1'b1, 3'd0);
    add_event(ACT_ERROR, 32'd95300, MODE_ACTIVE, 1'b1, 3'd0);
    add_event(ACT_ERROR, 32'd95400, MODE_ACTIVE, 1'b0, 3'd0);
    add_event(ACT_ERROR, 32'd95500, MODE_ACTIVE, 1'b1, STAT_TRANSITIONS);
    add_event(ACT_ERROR, 32'd95600, MODE_ACTIVE, 1'b0, 3'd0);
    add_event(ACT_ERROR, 32'd95700, MODE_ACTIVE, 1'b0, 3'd0);
    add_event(ACT_ERROR, 32'd95800, MODE_ACTIVE, 1'b0, 3'd0);
    add_event(ACT_ERROR, 32'd95900, MODE_ACTIVE, 1'b1, 3'd0);
    add_event(ACT_ACTIVITY, 32'hFFFF_FFF0, MODE_ACTIVE, 1'b0, 3'd0);
    add_event(ACT_REFRESH, 32'h0000_0010, MODE_ACTIVE, 1'b0, 3'd0);
    add_event(ACT_FORCE, 32'hFFFF_FFFF, MODE_ERROR, 1'b1, STAT_NONE);
    stamp_now = 32'hFFFF_FFFF;
    settle();

    // receiver holds off while the sender streams without gaps
    in_gap_max = 0;
    out_stall_max = 0;
    hold_left = 300;
    add_random_events(80);
    settle();

    // error limit zero: every error tries recovery
    program_regs(32'd0, 8'd0, 8'd255);
    in_gap_max = 5;
    out_stall_max = 0;
    add_event(ACT_ERROR, stamp_now, MODE_ACTIVE, 1'b0, 3'd0);
    add_event(ACT_ERROR, stamp_now, MODE_ACTIVE, 1'b1, 3'd0);
    add_event(ACT_INACTIVITY, stamp_now, MODE_ACTIVE, 1'b0, STAT_TRANSITIONS);
    add_random_events(80);
    settle();

    program_regs(32'hFFFF_FFFF, 8'd255, 8'd0);
    in_gap_max = 0;
    out_stall_max = 5;
    add_random_events(80);
    settle();

    program_regs(32'd50, 8'd1, 8'd2);
    in_gap_max = 5;
    out_stall_max = 5;
    add_random_events(60);
    settle();

    repeat (4) begin
      case ($urandom_range(0, 3))
        0:       timeout = '0;
        1:       timeout = $urandom_range(1, 200);
        2:       timeout = $urandom;
        default: timeout = $urandom_range(1000, 60000);
      endcase
      err_limit = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 4));
      rcv_limit = attempt_cnt + $urandom_range(0, 6);
      if (rcv_limit > 255) rcv_limit = 255;
      program_regs(timeout, err_limit, 8'(rcv_limit));
      in_gap_max = $urandom_range(0, 1) * 5;
      out_stall_max = $urandom_range(0, 1) * 5;
      add_random_events(60);
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && report_q.size() == 0) begin
      $display("power_mode_state_controller_core test passed");
    end else begin
      $display("power_mode_state_controller_core test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("power_mode_state_controller_core test failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/pmsc_pkg.sv
rtl/pmsc_if.sv
rtl/power_mode_state_controller_core.sv
verif/tb.sv
